[rtl/core/ow_pkg.sv]
package ow_pkg;

    localparam int TIME_W   = 10;
    localparam int CFG_CNT  = 7;
    localparam int CIDX_W   = 3;
    localparam int BIT_W    = 3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_RST_LOW   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PRES_SMP  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RST_REC   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SHORT_LOW = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_LONG_SLOT = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_RD_SMP    = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_RD_REC    = 3'd6;

    // reset values of the timing registers, in microseconds
    localparam logic [TIME_W-1:0] RST_LOW_DEF   = 10'd500;
    localparam logic [TIME_W-1:0] PRES_SMP_DEF  = 10'd60;
    localparam logic [TIME_W-1:0] RST_REC_DEF   = 10'd430;
    localparam logic [TIME_W-1:0] SHORT_LOW_DEF = 10'd3;
    localparam logic [TIME_W-1:0] LONG_SLOT_DEF = 10'd65;
    localparam logic [TIME_W-1:0] RD_SMP_DEF    = 10'd8;
    localparam logic [TIME_W-1:0] RD_REC_DEF    = 10'd55;

    typedef struct packed {
        logic [TIME_W-1:0] rst_low;
        logic [TIME_W-1:0] pres_smp;
        logic [TIME_W-1:0] rst_rec;
        logic [TIME_W-1:0] short_low;
        logic [TIME_W-1:0] long_slot;
        logic [TIME_W-1:0] rd_smp;
        logic [TIME_W-1:0] rd_rec;
    } t_cfg;

endpackage

[rtl/core/ow_cfg.sv]
module ow_cfg
    import ow_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [CIDX_W-1:0] i_wr_index,
    input  logic [TIME_W-1:0] i_wr_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rst_low   <= RST_LOW_DEF;
            r_cfg.pres_smp  <= PRES_SMP_DEF;
            r_cfg.rst_rec   <= RST_REC_DEF;
            r_cfg.short_low <= SHORT_LOW_DEF;
            r_cfg.long_slot <= LONG_SLOT_DEF;
            r_cfg.rd_smp    <= RD_SMP_DEF;
            r_cfg.rd_rec    <= RD_REC_DEF;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_RST_LOW:   r_cfg.rst_low   <= i_wr_data;
                CFG_PRES_SMP:  r_cfg.pres_smp  <= i_wr_data;
                CFG_RST_REC:   r_cfg.rst_rec   <= i_wr_data;
                CFG_SHORT_LOW: r_cfg.short_low <= i_wr_data;
                CFG_LONG_SLOT: r_cfg.long_slot <= i_wr_data;
                CFG_RD_SMP:    r_cfg.rd_smp    <= i_wr_data;
                CFG_RD_REC:    r_cfg.rd_rec    <= i_wr_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/ow_seq.sv]
module ow_seq
    import ow_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_command,
    input  logic [7:0] i_write_data,
    input  logic       i_line_level,
    input  logic       i_tick,
    input  t_cfg       i_cfg,
    output logic       o_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_presence_found,
    output logic [7:0] o_read_data
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RST_LOW = 4'd1,
        PH_RST_REL = 4'd2,
        PH_RST_REC = 4'd3,
        PH_W0_LOW  = 4'd4,
        PH_W1_LOW  = 4'd5,
        PH_W1_REL  = 4'd6,
        PH_RD_LOW  = 4'd7,
        PH_RD_WAIT = 4'd8,
        PH_RD_REC  = 4'd9
    } t_phase;

    t_phase            r_phase,    n_phase;
    logic [TIME_W-1:0] r_time,     n_time;
    logic [BIT_W-1:0]  r_bit,      n_bit;
    logic [7:0]        r_shift,    n_shift;
    logic              r_presence, n_presence;
    logic [7:0]        r_rd_byte,  n_rd_byte;
    logic              r_drive,    r_busy, r_done, n_done;
    logic [TIME_W-1:0] limit;
    logic [TIME_W-1:0] time_inc;
    logic [BIT_W-1:0]  bit_nxt;

    always_comb begin
        unique case (r_phase)
            PH_RST_LOW: limit = i_cfg.rst_low;
            PH_RST_REL: limit = i_cfg.pres_smp;
            PH_RST_REC: limit = i_cfg.rst_rec;
            PH_W0_LOW:  limit = i_cfg.long_slot;
            PH_W1_LOW:  limit = i_cfg.short_low;
            PH_W1_REL:  limit = i_cfg.long_slot;
            PH_RD_LOW:  limit = i_cfg.short_low;
            PH_RD_WAIT: limit = i_cfg.rd_smp;
            PH_RD_REC:  limit = i_cfg.rd_rec;
            default:    limit = '0;
        endcase
    end

    assign time_inc = (i_tick && (r_time != TIME_MAX)) ? r_time + 1'b1 : r_time;
    assign bit_nxt  = r_bit + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_time     = r_time;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_rd_byte  = r_rd_byte;
        n_done     = 1'b0;
        unique case (r_phase)
            PH_RST_LOW, PH_RST_REL, PH_RST_REC, PH_W0_LOW, PH_W1_LOW,
            PH_W1_REL, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC: begin
                n_time = time_inc;
                if (time_inc >= limit) begin
                    n_time = '0;
                    unique case (r_phase)
                        PH_RST_LOW: n_phase = PH_RST_REL;
                        PH_RST_REL: begin
                            n_presence = ~i_line_level;
                            n_phase    = PH_RST_REC;
                        end
                        PH_RST_REC: begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                        PH_W1_LOW: n_phase = PH_W1_REL;
                        PH_W0_LOW, PH_W1_REL: begin
                            if (&r_bit) begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end else begin
                                n_bit   = bit_nxt;
                                n_phase = r_shift[bit_nxt] ? PH_W1_LOW : PH_W0_LOW;
                            end
                        end
                        PH_RD_LOW: n_phase = PH_RD_WAIT;
                        PH_RD_WAIT: begin
                            n_shift[r_bit] = r_shift[r_bit] | i_line_level;
                            n_phase        = PH_RD_REC;
                        end
                        default: begin  // read recovery
                            if (&r_bit) begin
                                n_rd_byte = r_shift;
                                n_phase   = PH_IDLE;
                                n_done    = 1'b1;
                            end else begin
                                n_bit   = bit_nxt;
                                n_phase = PH_RD_LOW;
                            end
                        end
                    endcase
                end
            end
            default: begin  // idle, and codes without meaning
                n_phase = PH_IDLE;
                if (i_command != CMD_NONE) begin
                    n_time = '0;
                    n_bit  = '0;
                    unique case (i_command)
                        CMD_RESET: n_phase = PH_RST_LOW;
                        CMD_WRITE: begin
                            n_shift = i_write_data;
                            n_phase = i_write_data[0] ? PH_W1_LOW : PH_W0_LOW;
                        end
                        default: begin
                            n_shift = '0;
                            n_phase = PH_RD_LOW;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_time     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_rd_byte  <= '0;
            r_drive    <= 1'b0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_time     <= n_time;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_rd_byte  <= n_rd_byte;
            r_drive    <= (n_phase == PH_RST_LOW) || (n_phase == PH_W0_LOW) ||
                          (n_phase == PH_W1_LOW)  || (n_phase == PH_RD_LOW);
            r_busy     <= (n_phase != PH_IDLE);
            r_done     <= n_done;
        end
    end

    assign o_drive_low      = r_drive;
    assign o_busy_res       = r_busy;
    assign o_done_res       = r_done;
    assign o_presence_found = r_presence;
    assign o_read_data      = r_rd_byte;

endmodule

[rtl/core/one_wire_bus_master_core.sv]
// An accepted request passes the input register, then the result register, to its result.
// Throughput: one request per cycle while the result is not stalled; the bus sequencer
// steps once per request. A stalled result holds the sequencer; the input register then
// takes one more request and holds it until the result moves on.
// Reset (i_rst_n low at a clock edge) clears both valid flags, idles the bus, drops the
// presence flag and read byte to zero and reloads the timing registers to their defaults.
module one_wire_bus_master_core
    import ow_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_write_data,
    input  logic              i_line_level,
    input  logic              i_tick,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_drive_low,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic              o_presence_found,
    output logic [7:0]        o_read_data,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    // input register: holds one request until the sequencer takes it
    logic       r_in_vld;
    logic [1:0] r_command;
    logic [7:0] r_write_data;
    logic       r_line_level;
    logic       r_tick;
    logic       r_out_vld;
    logic       out_free;
    logic       step;
    t_cfg       cfg;

    // advance the sequencer when a request is held and the result slot frees up
    assign out_free   = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld <= i_in_valid || (r_in_vld && !step);
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // payload needs no reset; load on every accepted request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command    <= i_command;
            r_write_data <= i_write_data;
            r_line_level <= i_line_level;
            r_tick       <= i_tick;
        end
    end

    ow_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // sequencer state and result register advance together
    ow_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_command        (r_command),
        .i_write_data     (r_write_data),
        .i_line_level     (r_line_level),
        .i_tick           (r_tick),
        .i_cfg            (cfg),
        .o_drive_low      (o_drive_low),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_presence_found (o_presence_found),
        .o_read_data      (o_read_data)
    );

    assign o_out_valid = r_out_vld;

endmodule

[rtl/core/ow_checker.sv]
module ow_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_drive_low,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_read_data
);

    // a finished operation leaves the bus idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done shown while busy");

    // the line is only pulled low during an operation
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res)
        else $error("line driven while idle");

    // no result comes out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result changed");

endmodule

bind one_wire_bus_master_core ow_checker u_ow_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive_low (o_drive_low),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_read_data (o_read_data)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ow_pkg::*;

    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = 2000;

    // Sequencer phases of the bus master, as the block steps through them.
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_REL,
        SEQ_RST_REC,
        SEQ_W0_LOW,
        SEQ_W1_LOW,
        SEQ_W1_REL,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_REC
    } t_bus_seq;

    // Receiver behavior on the result channel.
    typedef enum logic [1:0] {
        TAKE_ALL,
        TAKE_SOME,
        TAKE_NONE
    } t_take_mode;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
    } t_bus_status;

    // Tracks the bus sequencer one request at a time and holds the status
    // words that the block owes us, oldest first.
    class bus_master_tracker;
        bit [TIME_W-1:0] timing [CFG_CNT];
        t_bus_seq        seq;
        bit [TIME_W-1:0] elapsed;
        bit [BIT_W-1:0]  slot;
        bit [7:0]        shifter;
        bit              presence;
        bit [7:0]        last_read;
        int unsigned     errors;
        t_bus_status     expected_status [$];

        function new();
            timing[CFG_RST_LOW]   = RST_LOW_DEF;
            timing[CFG_PRES_SMP]  = PRES_SMP_DEF;
            timing[CFG_RST_REC]   = RST_REC_DEF;
            timing[CFG_SHORT_LOW] = SHORT_LOW_DEF;
            timing[CFG_LONG_SLOT] = LONG_SLOT_DEF;
            timing[CFG_RD_SMP]    = RD_SMP_DEF;
            timing[CFG_RD_REC]    = RD_REC_DEF;
            seq = SEQ_IDLE;
        endfunction

        function void set_timing(int idx, bit [TIME_W-1:0] value);
            timing[idx] = value;
        endfunction

        function bit idle();
            return seq == SEQ_IDLE;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function t_bus_seq write_slot();
            if (shifter[slot])
                return SEQ_W1_LOW;
            return SEQ_W0_LOW;
        endfunction

        function bit [TIME_W-1:0] phase_time(t_bus_seq p);
            case (p)
                SEQ_RST_LOW: return timing[CFG_RST_LOW];
                SEQ_RST_REL: return timing[CFG_PRES_SMP];
                SEQ_RST_REC: return timing[CFG_RST_REC];
                SEQ_W0_LOW:  return timing[CFG_LONG_SLOT];
                SEQ_W1_LOW:  return timing[CFG_SHORT_LOW];
                SEQ_W1_REL:  return timing[CFG_LONG_SLOT];
                SEQ_RD_LOW:  return timing[CFG_SHORT_LOW];
                SEQ_RD_WAIT: return timing[CFG_RD_SMP];
                SEQ_RD_REC:  return timing[CFG_RD_REC];
                default:     return '0;
            endcase
        endfunction

        // Advance the sequencer by one accepted request and queue its status.
        function void note_request(logic [1:0] cmd, logic [7:0] wdata, logic line, logic tick);
            t_bus_status st;
            bit          finished;
            finished = 1'b0;
            if (seq == SEQ_IDLE) begin
                if (cmd != CMD_NONE) begin
                    elapsed = '0;
                    slot    = '0;
                    if (cmd == CMD_RESET) begin
                        seq = SEQ_RST_LOW;
                    end else if (cmd == CMD_WRITE) begin
                        shifter = wdata;
                        seq     = write_slot();
                    end else begin
                        shifter = '0;
                        seq     = SEQ_RD_LOW;
                    end
                end
            end else begin
                // Count microseconds, holding at the top of the counter.
                if (tick && elapsed != TIME_MAX)
                    elapsed++;
                if (elapsed >= phase_time(seq)) begin
                    elapsed = '0;
                    case (seq)
                        SEQ_RST_LOW: seq = SEQ_RST_REL;
                        SEQ_RST_REL: begin
                            presence = ~line;
                            seq      = SEQ_RST_REC;
                        end
                        SEQ_RST_REC: begin
                            seq      = SEQ_IDLE;
                            finished = 1'b1;
                        end
                        SEQ_W1_LOW:  seq = SEQ_W1_REL;
                        SEQ_W0_LOW, SEQ_W1_REL: begin
                            if (slot == 3'd7) begin
                                seq      = SEQ_IDLE;
                                finished = 1'b1;
                            end else begin
                                slot++;
                                seq = write_slot();
                            end
                        end
                        SEQ_RD_LOW:  seq = SEQ_RD_WAIT;
                        SEQ_RD_WAIT: begin
                            shifter[slot] = line;
                            seq           = SEQ_RD_REC;
                        end
                        default: begin
                            if (slot == 3'd7) begin
                                last_read = shifter;
                                seq       = SEQ_IDLE;
                                finished  = 1'b1;
                            end else begin
                                slot++;
                                seq = SEQ_RD_LOW;
                            end
                        end
                    endcase
                end
            end
            st.drive_low = (seq == SEQ_RST_LOW) || (seq == SEQ_W0_LOW) ||
                           (seq == SEQ_W1_LOW) || (seq == SEQ_RD_LOW);
            st.busy      = (seq != SEQ_IDLE);
            st.done      = finished;
            st.presence  = presence;
            st.read_data = last_read;
            expected_status.push_back(st);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field,
                             want, got);
            end
        endfunction

        function void check_status(t_bus_status got);
            t_bus_status want;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: status %h arrived with none outstanding", $realtime, got);
                return;
            end
            want = expected_status.pop_front();
            compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
            compare_field("busy", 8'(want.busy), 8'(got.busy));
            compare_field("done", 8'(want.done), 8'(got.done));
            compare_field("presence", 8'(want.presence), 8'(got.presence));
            compare_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command = CMD_NONE;
    logic [7:0]        i_write_data = '0;
    logic              i_line_level = 1'b1;
    logic              i_tick = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_drive_low;
    logic              o_busy_res;
    logic              o_done_res;
    logic              o_presence_found;
    logic [7:0]        o_read_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0] i_cfg_data = '0;

    bus_master_tracker tracker;
    bit [TIME_W-1:0]   timing_plan [CFG_CNT];
    int                burst_left = 0;
    t_take_mode        take_mode = TAKE_ALL;
    int                take_left = 0;
    int                quiet_cycles = 0;

    one_wire_bus_master_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_write_data     (i_write_data),
        .i_line_level     (i_line_level),
        .i_tick           (i_tick),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_low      (o_drive_low),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_presence_found (o_presence_found),
        .o_read_data      (o_read_data),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: switch between taking everything, taking at random and a
    // hard stall, each for a random stretch.
    always @(negedge i_clk) begin
        if (take_left == 0) begin
            take_mode = t_take_mode'($urandom_range(0, 2));
            take_left = (take_mode == TAKE_NONE) ? $urandom_range(1, 16)
                                                 : $urandom_range(1, 60);
        end
        take_left--;
        case (take_mode)
            TAKE_ALL:  i_out_ready <= 1'b1;
            TAKE_SOME: i_out_ready <= 1'($urandom);
            default:   i_out_ready <= 1'b0;
        endcase
    end

    // Check every status word the receiver takes against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            tracker.check_status({o_drive_low, o_busy_res, o_done_res, o_presence_found,
                                  o_read_data});
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the block takes it. Requests go
    // out in bursts; between bursts drop valid for a random gap.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                                input logic line, input logic tick);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 48);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_write_data <= data;
        i_line_level <= line;
        i_tick       <= tick;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_request(cmd, data, line, tick);
    endtask

    // Start commands mostly when the bus is idle; while busy, throw in an
    // occasional command that the block must ignore.
    task automatic random_request(input int tick_pct);
        logic [1:0] cmd;
        if (tracker.idle())
            cmd = ($urandom_range(0, 3) == 0) ? CMD_NONE : 2'($urandom_range(1, 3));
        else
            cmd = ($urandom_range(0, 7) == 0) ? 2'($urandom) : CMD_NONE;
        send_request(cmd, 8'($urandom), 1'($urandom), $urandom_range(0, 99) < tick_pct);
    endtask

    task automatic run_random(input int count, input int tick_pct);
        repeat (count) random_request(tick_pct);
    endtask

    // Tick the bus along with no new command until the operation ends.
    task automatic wait_idle();
        while (!tracker.idle())
            send_request(CMD_NONE, 8'($urandom), 1'($urandom), 1'b1);
    endtask

    // Let every status word drain, then load the timing registers from
    // timing_plan. A running operation carries on under the new timing.
    task automatic apply_timing();
        int idx;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        for (idx = 0; idx < CFG_CNT; idx++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[CIDX_W-1:0];
            i_cfg_data  <= timing_plan[idx];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            tracker.set_timing(idx, timing_plan[idx]);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int k;
        int r;
        tracker = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default timing: long phases, only the first slots of an operation end.
        run_random(120, 90);

        // Zero on every register: each phase lasts a single step.
        for (k = 0; k < CFG_CNT; k++) timing_plan[k] = '0;
        apply_timing();
        wait_idle();
        send_request(CMD_NONE, 8'hFF, 1'b1, 1'b1);    // idle, no command: nothing moves
        send_request(CMD_RESET, 8'h00, 1'b1, 1'b0);   // start a bus reset without a tick
        send_request(CMD_READ, 8'hFF, 1'b1, 1'b1);    // busy: command dropped
        send_request(CMD_WRITE, 8'h00, 1'b0, 1'b0);   // line low at the sample: presence
        send_request(CMD_READ, 8'h00, 1'b1, 1'b1);    // command on the finishing step
        send_request(CMD_WRITE, 8'h00, 1'b1, 1'b0);   // all-zero byte: back-to-back long lows
        repeat (8) send_request(CMD_RESET, 8'hFF, 1'b0, 1'b1);
        send_request(CMD_READ, 8'h00, 1'b0, 1'b0);    // read keeps the old byte until done
        for (k = 0; k < 9; k++) send_request(CMD_NONE, 8'h00, k[0], 1'b1);
        run_random(120, 50);

        // Top of range on every register: long phases, nothing ends early.
        for (k = 0; k < CFG_CNT; k++) timing_plan[k] = TIME_MAX;
        apply_timing();
        run_random(60, 100);

        // Bottom of the legal range.
        for (k = 0; k < CFG_CNT; k++) timing_plan[k] = 10'd1;
        apply_timing();
        run_random(100, 70);

        // Short random timings, now and then one longer phase.
        repeat (5) begin
            for (k = 0; k < CFG_CNT; k++) begin
                r = $urandom_range(0, 9);
                timing_plan[k] = (r < 7) ? TIME_W'(r) : TIME_W'($urandom_range(7, 40));
            end
            apply_timing();
            run_random(100, $urandom_range(30, 100));
        end

        // Drop valid, collect everything still owed, then let the pipe settle.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
